>>> rtl/core/rsap_pkg.sv
// Shared types, register indexes and mode codes for the search and attack policy.
// No dependencies; imported by rsap_decide, robot_search_attack_policy and tb_top.
`timescale 1ns / 1ps

package rsap_pkg;

    localparam int RANGE_INTERVAL_MS_DEF  = 50;
    localparam int WINDOW_DURATION_MS_DEF = 2000;

    localparam int SPEED_W = 8;
    localparam int CMD_W   = 9;
    localparam int MM_W    = 13;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGER_PRESENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_FULL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_REDUCED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_THRESHOLD = 3'd7;

    typedef enum logic [2:0] {
        MODE_DEFAULT  = 3'd0,
        MODE_SLOW     = 3'd1,
        MODE_DISTANCE = 3'd2,
        MODE_CURVE    = 3'd3,
        MODE_WINDOW   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]         search_mode;
        logic               ranger_present;
        logic [SPEED_W-1:0] turn_speed;
        logic [SPEED_W-1:0] slow_speed;
        logic [SPEED_W-1:0] attack_full;
        logic [SPEED_W-1:0] attack_reduced;
        logic [MM_W-1:0]    near_threshold;
        logic [MM_W-1:0]    window_threshold;
    } t_cfg;

    typedef struct packed {
        logic              last_side_right;
        logic [TIME_W-1:0] last_range_time;
        logic              range_near;
        logic [TIME_W-1:0] window_start;
        logic              window_started;
        t_mode             active_mode;
    } t_state;

    typedef struct packed {
        logic              macro_busy;
        logic [TIME_W-1:0] now_ms;
        logic              range_valid;
        logic [MM_W-1:0]   range_mm;
        logic              sees_front;
        logic              sees_right;
        logic              sees_left;
    } t_frame;

    typedef struct packed {
        logic              macro_right;
        logic              macro_start;
        logic              drive_valid;
        logic signed [CMD_W-1:0] right_speed;
        logic signed [CMD_W-1:0] left_speed;
    } t_result;

    // Modes needing an absent ranger, and codes past the list, fall back to default.
    function automatic t_mode resolve_mode(input logic [2:0] sm, input logic rp);
        t_mode m;
        case (sm)
            MODE_SLOW:     m = MODE_SLOW;
            MODE_DISTANCE: m = rp ? MODE_DISTANCE : MODE_DEFAULT;
            MODE_CURVE:    m = rp ? MODE_CURVE : MODE_DEFAULT;
            MODE_WINDOW:   m = MODE_WINDOW;
            default:       m = MODE_DEFAULT;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/core/robot_search_attack_policy.sv
// Search and attack policy: input register, decision logic, result register.
// Frames pass both registers in turn; one frame per cycle while the receiver is ready.
// The policy state updates as a frame leaves the input register, so frames chain
// back to back. Synchronous active-low reset clears configuration and state,
// active mode default; no clearing pass. Depends on rsap_pkg and rsap_decide.
`timescale 1ns / 1ps

module robot_search_attack_policy #(
    parameter int RANGE_INTERVAL_MS  = rsap_pkg::RANGE_INTERVAL_MS_DEF,
    parameter int WINDOW_DURATION_MS = rsap_pkg::WINDOW_DURATION_MS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rsap_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rsap_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sees_left, sees_right, sees_front, range_mm[13], range_valid, now_ms[32],
    // macro_busy, zero fill
    input  logic [rsap_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // left_speed[9], right_speed[9], drive_valid, macro_start, macro_right, zero fill
    output logic [rsap_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import rsap_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_state  r_state, n_state, dec_state;
    t_frame  r_frame;
    t_result r_result, dec_result;
    logic    r_in_valid, r_out_valid;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_result};

    rsap_decide #(
        .RANGE_INTERVAL_MS  (RANGE_INTERVAL_MS),
        .WINDOW_DURATION_MS (WINDOW_DURATION_MS)
    ) u_decide (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_frame  (r_frame),
        .o_state  (dec_state),
        .o_result (dec_result)
    );

    always_comb begin
        n_cfg   = r_cfg;
        n_state = advance ? dec_state : r_state;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEARCH_MODE:      n_cfg.search_mode      = i_cfg_data[2:0];
                REG_RANGER_PRESENT:   n_cfg.ranger_present   = i_cfg_data[0];
                REG_TURN_SPEED:       n_cfg.turn_speed       = i_cfg_data[SPEED_W-1:0];
                REG_SLOW_SPEED:       n_cfg.slow_speed       = i_cfg_data[SPEED_W-1:0];
                REG_ATTACK_FULL:      n_cfg.attack_full      = i_cfg_data[SPEED_W-1:0];
                REG_ATTACK_REDUCED:   n_cfg.attack_reduced   = i_cfg_data[SPEED_W-1:0];
                REG_NEAR_THRESHOLD:   n_cfg.near_threshold   = i_cfg_data[MM_W-1:0];
                REG_WINDOW_THRESHOLD: n_cfg.window_threshold = i_cfg_data[MM_W-1:0];
                default: begin
                end
            endcase
            // A mode or ranger write restarts the search from a clean state.
            if (i_cfg_idx == REG_SEARCH_MODE || i_cfg_idx == REG_RANGER_PRESENT) begin
                n_state.active_mode     = resolve_mode(n_cfg.search_mode,
                                                       n_cfg.ranger_present);
                n_state.last_range_time = '0;
                n_state.range_near      = 1'b0;
                n_state.window_start    = '0;
                n_state.window_started  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg   <= n_cfg;
            r_state <= n_state;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_frame <= s_axis_tdata[$bits(t_frame)-1:0];
        end
        if (advance) begin
            r_result <= dec_result;
        end
    end

`ifndef SYNTHESIS
    a_macro_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.macro_start && r_result.drive_valid))
        else $error("macro start issued together with a drive command");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are held");

    a_mode_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == REG_SEARCH_MODE || i_cfg_idx == REG_RANGER_PRESENT))
        |=> (!r_state.window_started && !r_state.range_near))
        else $error("mode write did not clear the search state");

    a_busy_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_frame.macro_busy && !i_cfg_we) |=> $stable(r_state))
        else $error("state changed during a busy frame");
`endif

endmodule

>>> rtl/core/rsap_decide.sv
// Per-frame decision logic: next state and the wheel or macro command.
// Depends on rsap_pkg.
`timescale 1ns / 1ps

module rsap_decide #(
    parameter int RANGE_INTERVAL_MS  = rsap_pkg::RANGE_INTERVAL_MS_DEF,
    parameter int WINDOW_DURATION_MS = rsap_pkg::WINDOW_DURATION_MS_DEF
) (
    input  rsap_pkg::t_cfg    i_cfg,
    input  rsap_pkg::t_state  i_state,
    input  rsap_pkg::t_frame  i_frame,
    output rsap_pkg::t_state  o_state,
    output rsap_pkg::t_result o_result
);
    import rsap_pkg::*;

    localparam logic [TIME_W-1:0] INTERVAL = TIME_W'(RANGE_INTERVAL_MS);
    localparam logic [TIME_W-1:0] DURATION = TIME_W'(WINDOW_DURATION_MS);

    logic              side_right;
    logic              sampling;
    logic              sample_due;
    logic [MM_W-1:0]   thr;
    logic              valid_eff;
    logic              near_eff;
    logic [TIME_W-1:0] start_eff;
    logic              expired;
    logic signed [CMD_W-1:0] full_s, red_s, turn_p, turn_n, slow_p, slow_n;
    logic signed [CMD_W-1:0] att_l, att_r;

    always_comb begin
        side_right = i_frame.sees_left ? 1'b0 :
                     (i_frame.sees_right ? 1'b1 : i_state.last_side_right);
        full_s = $signed({1'b0, i_cfg.attack_full});
        red_s  = $signed({1'b0, i_cfg.attack_reduced});
        turn_p = $signed({1'b0, i_cfg.turn_speed});
        turn_n = -turn_p;
        slow_p = $signed({1'b0, i_cfg.slow_speed});
        slow_n = -slow_p;

        // Attack steering: one side bit alone slows the wheel on that side.
        if (i_frame.sees_front || (i_frame.sees_left && i_frame.sees_right)) begin
            att_l = full_s;
            att_r = full_s;
        end else if (i_frame.sees_left) begin
            att_l = red_s;
            att_r = full_s;
        end else if (i_frame.sees_right) begin
            att_l = full_s;
            att_r = red_s;
        end else begin
            att_l = '0;
            att_r = '0;
        end

        sampling = (i_state.active_mode == MODE_DISTANCE) ||
                   (i_state.active_mode == MODE_CURVE) ||
                   (i_state.active_mode == MODE_WINDOW);
        sample_due = (i_frame.now_ms - i_state.last_range_time) >= INTERVAL;
        thr = (i_state.active_mode == MODE_WINDOW) ? i_cfg.window_threshold
                                                   : i_cfg.near_threshold;
        valid_eff = i_frame.range_valid &&
                    ((i_state.active_mode != MODE_WINDOW) || i_cfg.ranger_present);

        o_state = i_state;
        o_state.last_side_right = side_right;
        if (sampling && sample_due) begin
            o_state.last_range_time = i_frame.now_ms;
            o_state.range_near      = valid_eff && (i_frame.range_mm < thr);
        end
        near_eff = o_state.range_near;

        start_eff = i_state.window_started ? i_state.window_start : i_frame.now_ms;
        expired   = (i_frame.now_ms - start_eff) >= DURATION;

        o_result = '0;
        o_result.drive_valid = 1'b1;
        // By default attack on a front sighting, else spin toward the last side seen.
        if (i_frame.sees_front) begin
            o_result.left_speed  = att_l;
            o_result.right_speed = att_r;
        end else begin
            o_result.left_speed  = side_right ? turn_p : turn_n;
            o_result.right_speed = side_right ? turn_n : turn_p;
        end

        case (i_state.active_mode)
            MODE_SLOW: begin
                if (!i_frame.sees_front) begin
                    o_result.left_speed  = side_right ? slow_p : slow_n;
                    o_result.right_speed = side_right ? slow_n : slow_p;
                end
            end
            MODE_DISTANCE: begin
                if (near_eff) begin
                    o_result.left_speed  = full_s;
                    o_result.right_speed = full_s;
                end else begin
                    o_result.left_speed  = side_right ? slow_p : slow_n;
                    o_result.right_speed = side_right ? slow_n : slow_p;
                end
            end
            MODE_CURVE: begin
                if (near_eff) begin
                    o_result = '0;
                    o_result.macro_start = 1'b1;
                    o_result.macro_right = side_right;
                end else begin
                    o_result.left_speed  = side_right ? slow_p : slow_n;
                    o_result.right_speed = side_right ? slow_n : slow_p;
                end
            end
            MODE_WINDOW: begin
                o_state.window_started = 1'b1;
                o_state.window_start   = start_eff;
                if (near_eff || expired) begin
                    // Window over: default search runs in this same frame.
                    o_state.active_mode = MODE_DEFAULT;
                end else begin
                    o_result.left_speed  = side_right ? slow_p : slow_n;
                    o_result.right_speed = side_right ? slow_n : slow_p;
                end
            end
            default: begin
            end
        endcase

        // While a macro owns the motors nothing is commanded and nothing moves.
        if (i_frame.macro_busy) begin
            o_state  = i_state;
            o_result = '0;
        end
    end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for robot_search_attack_policy: directed frames, then random phases.
// A scoreboard class predicts each command from the accepted frames; depends on rsap_pkg.
`timescale 1ns / 1ps

module tb_top;
    import rsap_pkg::*;

    localparam int RANGE_MS    = RANGE_INTERVAL_MS_DEF;
    localparam int WINDOW_MS   = WINDOW_DURATION_MS_DEF;
    localparam int ITEM_TARGET = 1950;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;

    class policy_scoreboard;
        t_cfg        cfg;
        t_state      st;
        t_result     cmd_q[$];
        int unsigned n_fail;
        int unsigned n_checked;
        int unsigned n_macro;
        int unsigned n_fallback;
        int unsigned n_busy;

        function new();
            cfg = '0;
            st = '0;
            st.active_mode = MODE_DEFAULT;
            n_fail = 0;
            n_checked = 0;
            n_macro = 0;
            n_fallback = 0;
            n_busy = 0;
        endfunction

        // A mode or ranger write picks the mode again and restarts all timing state.
        function void reselect_mode();
            case (cfg.search_mode)
                MODE_SLOW:     st.active_mode = MODE_SLOW;
                MODE_DISTANCE: st.active_mode = cfg.ranger_present ? MODE_DISTANCE : MODE_DEFAULT;
                MODE_CURVE:    st.active_mode = cfg.ranger_present ? MODE_CURVE : MODE_DEFAULT;
                MODE_WINDOW:   st.active_mode = MODE_WINDOW;
                default:       st.active_mode = MODE_DEFAULT;
            endcase
            st.last_range_time = '0;
            st.range_near = 1'b0;
            st.window_start = '0;
            st.window_started = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEARCH_MODE: begin
                    cfg.search_mode = data[2:0];
                    reselect_mode();
                end
                REG_RANGER_PRESENT: begin
                    cfg.ranger_present = data[0];
                    reselect_mode();
                end
                REG_TURN_SPEED:       cfg.turn_speed = data[SPEED_W-1:0];
                REG_SLOW_SPEED:       cfg.slow_speed = data[SPEED_W-1:0];
                REG_ATTACK_FULL:      cfg.attack_full = data[SPEED_W-1:0];
                REG_ATTACK_REDUCED:   cfg.attack_reduced = data[SPEED_W-1:0];
                REG_NEAR_THRESHOLD:   cfg.near_threshold = data[MM_W-1:0];
                REG_WINDOW_THRESHOLD: cfg.window_threshold = data[MM_W-1:0];
                default: ;
            endcase
        endfunction

        function t_result drive_cmd(logic [CMD_W-1:0] lspd, logic [CMD_W-1:0] rspd);
            t_result res;
            res = '0;
            res.left_speed = lspd;
            res.right_speed = rspd;
            res.drive_valid = 1'b1;
            return res;
        endfunction

        function t_result attack_cmd(bit l, bit r, bit f);
            logic [CMD_W-1:0] full;
            logic [CMD_W-1:0] red;
            full = {1'b0, cfg.attack_full};
            red = {1'b0, cfg.attack_reduced};
            if (!f && !l && !r) return drive_cmd('0, '0);
            if (f) return drive_cmd(full, full);
            if (l && !r) return drive_cmd(red, full);
            if (r && !l) return drive_cmd(full, red);
            return drive_cmd(full, full);
        endfunction

        function t_result spin_cmd(logic [SPEED_W-1:0] mag, bit l, bit r);
            logic [CMD_W-1:0] pos;
            logic [CMD_W-1:0] neg;
            bit to_right;
            pos = {1'b0, mag};
            neg = -pos;
            to_right = l ? 1'b0 : (r ? 1'b1 : st.last_side_right);
            return to_right ? drive_cmd(pos, neg) : drive_cmd(neg, pos);
        endfunction

        function t_result default_cmd(t_frame fr);
            if (fr.sees_front) return attack_cmd(fr.sees_left, fr.sees_right, 1'b1);
            return spin_cmd(cfg.turn_speed, fr.sees_left, fr.sees_right);
        endfunction

        function void sample_range(logic [TIME_W-1:0] now, bit valid, logic [MM_W-1:0] mm,
                                   logic [MM_W-1:0] thr);
            logic [TIME_W-1:0] age;
            age = now - st.last_range_time;
            if (age >= 32'(RANGE_MS)) begin
                st.last_range_time = now;
                st.range_near = valid && (mm < thr);
            end
        endfunction

        function t_result policy_cmd(t_frame fr);
            t_result res;
            logic [TIME_W-1:0] elapsed;
            res = '0;
            // A busy macro owns the motors: zero command and the state is frozen.
            if (fr.macro_busy) begin
                n_busy++;
                return res;
            end
            if (fr.sees_left) st.last_side_right = 1'b0;
            else if (fr.sees_right) st.last_side_right = 1'b1;
            case (st.active_mode)
                MODE_SLOW: begin
                    if (fr.sees_front) res = attack_cmd(fr.sees_left, fr.sees_right, 1'b1);
                    else res = spin_cmd(cfg.slow_speed, fr.sees_left, fr.sees_right);
                end
                MODE_DISTANCE: begin
                    sample_range(fr.now_ms, fr.range_valid, fr.range_mm, cfg.near_threshold);
                    if (st.range_near) res = attack_cmd(fr.sees_left, fr.sees_right, 1'b1);
                    else res = spin_cmd(cfg.slow_speed, fr.sees_left, fr.sees_right);
                end
                MODE_CURVE: begin
                    sample_range(fr.now_ms, fr.range_valid, fr.range_mm, cfg.near_threshold);
                    if (st.range_near) begin
                        res.macro_start = 1'b1;
                        res.macro_right = st.last_side_right;
                        n_macro++;
                    end else begin
                        res = spin_cmd(cfg.slow_speed, fr.sees_left, fr.sees_right);
                    end
                end
                MODE_WINDOW: begin
                    if (!st.window_started) begin
                        st.window_started = 1'b1;
                        st.window_start = fr.now_ms;
                    end
                    sample_range(fr.now_ms, fr.range_valid && cfg.ranger_present, fr.range_mm,
                                 cfg.window_threshold);
                    elapsed = fr.now_ms - st.window_start;
                    if (st.range_near || elapsed >= 32'(WINDOW_MS)) begin
                        st.active_mode = MODE_DEFAULT;
                        n_fallback++;
                        res = default_cmd(fr);
                    end else begin
                        res = spin_cmd(cfg.slow_speed, fr.sees_left, fr.sees_right);
                    end
                end
                default: res = default_cmd(fr);
            endcase
            return res;
        endfunction

        function void note_frame(t_frame fr);
            cmd_q.push_back(policy_cmd(fr));
        endfunction

        function int unsigned outstanding();
            return cmd_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at result %0d: %s", n_checked, msg);
            n_fail++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] word);
            t_result got;
            t_result want;
            got = t_result'(word[$bits(t_result)-1:0]);
            if (cmd_q.size() == 0) begin
                report("command arrived with no frame outstanding");
                return;
            end
            want = cmd_q.pop_front();
            if (got.left_speed != want.left_speed)
                report($sformatf("left_speed %0d, expected %0d", got.left_speed, want.left_speed));
            if (got.right_speed != want.right_speed)
                report($sformatf("right_speed %0d, expected %0d",
                                 got.right_speed, want.right_speed));
            if (got.drive_valid != want.drive_valid)
                report($sformatf("drive_valid %0b, expected %0b",
                                 got.drive_valid, want.drive_valid));
            if (got.macro_start != want.macro_start)
                report($sformatf("macro_start %0b, expected %0b",
                                 got.macro_start, want.macro_start));
            if (got.macro_right != want.macro_right)
                report($sformatf("macro_right %0b, expected %0b",
                                 got.macro_right, want.macro_right));
            n_checked++;
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    policy_scoreboard sb = new();
    int unsigned n_sent = 0;
    int unsigned n_phases = 0;
    int unsigned hold_asks = 0;

    robot_search_attack_policy dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_frame frame_of(bit l, bit r, bit f, logic [MM_W-1:0] mm, bit valid,
                                        logic [TIME_W-1:0] now, bit busy);
        t_frame fr;
        fr.sees_left = l;
        fr.sees_right = r;
        fr.sees_front = f;
        fr.range_mm = mm;
        fr.range_valid = valid;
        fr.now_ms = now;
        fr.macro_busy = busy;
        return fr;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] speed_val();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return '0;
        if (pick < 4) return CFG_DATA_W'(255);
        return CFG_DATA_W'($urandom_range(1, 254));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] thr_val();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) return CFG_DATA_W'($urandom_range(0, 8191));
        if (pick < 8) return CFG_DATA_W'($urandom_range(50, 3000));
        return pick[0] ? 13'd8191 : 13'd0;
    endfunction

    // Distance modes are favored since they hold most of the state.
    function automatic logic [CFG_DATA_W-1:0] mode_val();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return CFG_DATA_W'(MODE_DEFAULT);
        if (pick < 30) return CFG_DATA_W'(MODE_SLOW);
        if (pick < 55) return CFG_DATA_W'(MODE_DISTANCE);
        if (pick < 80) return CFG_DATA_W'(MODE_CURVE);
        if (pick < 95) return CFG_DATA_W'(MODE_WINDOW);
        return CFG_DATA_W'($urandom_range(5, 7));  // codes past the mode list
    endfunction

    task automatic send_frame(t_frame fr, int unsigned gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(fr);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_frame(fr);
        n_sent++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering frames and wait until every predicted command has been seen.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_config(bit all_regs);
        bit ranger_first;
        ranger_first = 1'($urandom_range(0, 1));
        if (all_regs || $urandom_range(0, 9) < 6) write_reg(REG_TURN_SPEED, speed_val());
        if (all_regs || $urandom_range(0, 9) < 6) write_reg(REG_SLOW_SPEED, speed_val());
        if (all_regs || $urandom_range(0, 9) < 6) write_reg(REG_ATTACK_FULL, speed_val());
        if (all_regs || $urandom_range(0, 9) < 6) write_reg(REG_ATTACK_REDUCED, speed_val());
        if (all_regs || $urandom_range(0, 9) < 6) write_reg(REG_NEAR_THRESHOLD, thr_val());
        if (all_regs || $urandom_range(0, 9) < 6) write_reg(REG_WINDOW_THRESHOLD, thr_val());
        if (ranger_first)
            write_reg(REG_RANGER_PRESENT, CFG_DATA_W'($urandom_range(0, 9) < 8));
        write_reg(REG_SEARCH_MODE, mode_val());
        if (!ranger_first)
            write_reg(REG_RANGER_PRESENT, CFG_DATA_W'($urandom_range(0, 9) < 8));
        end_writes();
    endtask

    task automatic run_directed();
        // Default search at the speed extremes, side memory, and a busy frame.
        write_reg(REG_TURN_SPEED, 13'd255);
        write_reg(REG_ATTACK_FULL, 13'd255);
        write_reg(REG_ATTACK_REDUCED, 13'd0);
        write_reg(REG_RANGER_PRESENT, 13'd1);
        write_reg(REG_NEAR_THRESHOLD, 13'd8191);
        write_reg(REG_WINDOW_THRESHOLD, 13'd0);
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd0, 1'b0, 32'h0, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b1, 1'b0, 13'd8191, 1'b1, 32'hFFFF_FFFF, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd8191, 1'b1, 32'hFFFF_FFFF, 1'b0), 0);
        send_frame(frame_of(1'b1, 1'b1, 1'b1, 13'd8191, 1'b1, 32'hFFFF_FFFF, 1'b0), 0);
        send_frame(frame_of(1'b1, 1'b1, 1'b1, 13'd8191, 1'b1, 32'hFFFF_FFFF, 1'b1), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd0, 1'b0, 32'h0, 1'b0), 0);
        settle();
        write_reg(REG_SLOW_SPEED, 13'd255);
        write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_SLOW));
        end_writes();
        send_frame(frame_of(1'b1, 1'b0, 1'b0, 13'd0, 1'b0, 32'h0, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b1, 13'd0, 1'b0, 32'h0, 1'b0), 0);
        settle();
        // Distance attack: the verdict is only refreshed once the interval has passed.
        write_reg(REG_ATTACK_FULL, 13'd200);
        write_reg(REG_NEAR_THRESHOLD, 13'd100);
        write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_DISTANCE));
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd99, 1'b1, 32'd10, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd99, 1'b1, 32'd50, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd200, 1'b1, 32'd99, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd100, 1'b1, 32'd100, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd0, 1'b0, 32'd150, 1'b0), 0);
        settle();
        write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_CURVE));
        end_writes();
        send_frame(frame_of(1'b0, 1'b1, 1'b0, 13'd0, 1'b1, 32'd60, 1'b0), 0);
        send_frame(frame_of(1'b1, 1'b0, 1'b0, 13'd0, 1'b1, 32'd200, 1'b0), 0);
        settle();
        // Without the ranger the distance mode falls back to the default search, as does code 7.
        write_reg(REG_RANGER_PRESENT, 13'd0);
        write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_DISTANCE));
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd0, 1'b1, 32'd100, 1'b0), 0);
        settle();
        write_reg(REG_SEARCH_MODE, 13'd7);
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b1, 13'd0, 1'b1, 32'd100, 1'b0), 0);
        settle();
        // Timed window across the timestamp wrap, ending on the duration.
        write_reg(REG_RANGER_PRESENT, 13'd1);
        write_reg(REG_WINDOW_THRESHOLD, 13'd500);
        write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_WINDOW));
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd8191, 1'b1, 32'hFFFF_FC00, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd8191, 1'b1, 32'h0000_03CF, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd8191, 1'b1, 32'h0000_03D0, 1'b0), 0);
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd8191, 1'b1, 32'h0000_0400, 1'b0), 0);
        settle();
        // Timed window ended by a near sample, then the same sample with no ranger.
        write_reg(REG_SEARCH_MODE, CFG_DATA_W'(MODE_WINDOW));
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd10, 1'b1, 32'd100, 1'b0), 0);
        settle();
        write_reg(REG_RANGER_PRESENT, 13'd0);
        end_writes();
        send_frame(frame_of(1'b0, 1'b0, 1'b0, 13'd10, 1'b1, 32'd100, 1'b0), 0);
        settle();
    endtask

    task automatic random_phase(int unsigned phase);
        int unsigned len;
        int unsigned pick;
        int          mm_int;
        bit          burst;
        bit [2:0]    seen;
        logic [TIME_W-1:0] now;
        logic [MM_W-1:0]   thr;
        logic [MM_W-1:0]   mm;
        t_frame      fr;
        random_config(phase == 0);
        len = $urandom_range(20, 120);
        burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        else now = $urandom;
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) now = now + $urandom_range(0, 40);
            else if (pick < 90) now = now + $urandom_range(40, 150);
            else now = $urandom;
            seen = ($urandom_range(0, 9) < 4) ? 3'b000 : 3'($urandom_range(0, 7));
            thr = (sb.st.active_mode == MODE_WINDOW) ? sb.cfg.window_threshold
                                                     : sb.cfg.near_threshold;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                mm = MM_W'($urandom_range(0, 8191));
            end else if (pick < 8) begin
                mm_int = int'(thr) + int'($urandom_range(0, 80)) - 40;
                if (mm_int < 0) mm_int = 0;
                else if (mm_int > 8191) mm_int = 8191;
                mm = 13'(mm_int);
            end else begin
                mm = pick[0] ? 13'd8191 : 13'd0;
            end
            fr = frame_of(seen[0], seen[1], seen[2], mm, $urandom_range(0, 99) < 85, now,
                          $urandom_range(0, 99) < 8);
            // Long receiver hold-off while frames keep coming, to back up the pipeline.
            if (phase == 2 && k == 5) hold_asks <= hold_asks + 1;
            if (phase == 4 && k == len / 2) settle();
            send_frame(fr, burst ? 0 : gap_len());
        end
        settle();
    endtask

    initial begin : receiver
        bit          rx_on;
        int unsigned rx_left;
        int unsigned holds_seen;
        rx_on = 1'b0;
        rx_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_seen) begin
                holds_seen = hold_asks;
                rx_on = 1'b0;
                rx_left = HOLD_CYCLES;
            end else if (rx_left != 0) begin
                rx_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                rx_on = 1'b1;
                rx_left = $urandom_range(50, 300);
            end else if (rx_on) begin
                rx_on = 1'b0;
                rx_left = gap_len();
            end else begin
                rx_on = 1'b1;
                rx_left = $urandom_range(0, 8);
            end
            m_axis_tready <= rx_on;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
            else idle++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        while (n_sent < ITEM_TARGET) begin
            random_phase(n_phases);
            n_phases++;
        end
        repeat (10) @(posedge i_clk);
        $display("Checked %0d commands from %0d frames over %0d random configuration phases.",
                 sb.n_checked, n_sent, n_phases);
        $display("Busy frames %0d, curve macro requests %0d, timed window fallbacks %0d.",
                 sb.n_busy, sb.n_macro, sb.n_fallback);
        if (sb.n_fail == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
